@@ rtl/panic_alarm_passcode_fsm_core_assert.svh @@
// Assertion macros shared by the panic alarm RTL.
`ifndef PANIC_ALARM_PASSCODE_FSM_CORE_ASSERT_SVH
`define PANIC_ALARM_PASSCODE_FSM_CORE_ASSERT_SVH

// Same-cycle implication, skipped while in reset
`define PAP_ASSERT_NOW(label, clk, rst, cond, expect_now) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_now)) \
    else $error("pap: same-cycle check failed");

// Next-cycle implication, skipped while in reset
`define PAP_ASSERT_NEXT(label, clk, rst, cond, expect_next) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_next)) \
    else $error("pap: next-cycle check failed");

`endif

@@ rtl/pap_pkg.sv @@
// Shared types, constants and codes for the panic alarm passcode controller.
package pap_pkg;

  localparam int CODE_LENGTH      = 5;
  localparam int CODE_BITS        = 10;
  localparam int CNT_W            = $clog2(CODE_LENGTH + 1);
  localparam int TICKS_PER_SECOND = 20;
  localparam int SUB_W            = $clog2(TICKS_PER_SECOND);
  localparam int PADDR_W          = 5;

  typedef enum logic [2:0] {
    M_IDLE     = 3'd0,
    M_HELD     = 3'd1,
    M_ENTRY    = 3'd2,
    M_CANCELED = 3'd3,
    M_RETRY    = 3'd4,
    M_ALERT    = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_PRESS   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_DIGIT   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    VIB_NONE  = 2'd0,
    VIB_SHORT = 2'd1,
    VIB_ERROR = 2'd2,
    VIB_LONG  = 2'd3
  } vib_t;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_CODE_DIGITS  = 3'd0;
  localparam logic [2:0] REG_CODE_PRESENT = 3'd1;
  localparam logic [2:0] REG_COUNTDOWN    = 3'd2;
  localparam logic [2:0] REG_UNLOCK_HOLD  = 3'd3;
  localparam logic [2:0] REG_ALERT_HOLD   = 3'd4;

  typedef struct packed {
    logic [1:0] command;
    logic [1:0] key_digit;
  } in_word_t;

  typedef struct packed {
    logic [2:0] mode_now;
    logic [2:0] digits_entered;
    logic [8:0] seconds_left;
    logic [1:0] vibrate_code;
    logic       send_alert;
    logic       setup_warning;
  } out_word_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] code_digits;
    logic                 code_present;
    logic [7:0]           countdown_seconds;
    logic [7:0]           unlock_hold_ticks;
    logic [7:0]           alert_hold_ticks;
  } cfg_t;

  // Countdown is kept as whole seconds plus ticks within the second
  typedef struct packed {
    mode_t                       mode;
    logic [CNT_W-1:0]            entry_count;
    logic [CODE_LENGTH-1:0][1:0] entry_digits;
    logic [7:0]                  secs;
    logic [SUB_W-1:0]            sub_ticks;
    logic [7:0]                  hold_ticks;
  } state_t;

endpackage

@@ rtl/pap_step.sv @@
// One-word state update and result formation for the panic alarm controller.
module pap_step (
  input  pap_pkg::state_t    state,
  input  pap_pkg::cfg_t      cfg,
  input  pap_pkg::in_word_t  in_word,
  output pap_pkg::state_t    state_next,
  output pap_pkg::out_word_t out_word
);
  import pap_pkg::*;

  cmd_t                        cmd;
  mode_t                       mode_next;
  logic                        entering;
  logic                        entering_next;
  logic                        full;
  logic                        matched;
  logic                        cd_zero;
  logic                        hold_zero;
  logic [CODE_LENGTH-1:0][1:0] want;
  vib_t                        vib;
  logic                        alert;

  // Decode the word and the conditions the mode change depends on
  assign cmd       = cmd_t'(in_word.command);
  assign entering  = (state.mode == M_ENTRY) || (state.mode == M_RETRY);
  assign full      = (state.entry_count == CNT_W'(CODE_LENGTH));
  assign want      = (2 * CODE_LENGTH)'(cfg.code_digits);
  assign matched   = full && cfg.code_present && (state.entry_digits == want);
  // countdown is zero after this tick's decrement
  assign cd_zero   = (state.secs == 8'd0) && (state.sub_ticks <= SUB_W'(1));
  assign hold_zero = (state.hold_ticks <= 8'd1);

  // Next mode
  always_comb begin
    mode_next = state.mode;
    case (state.mode)
      M_IDLE: begin
        if (cmd == CMD_PRESS) mode_next = M_HELD;
      end
      M_HELD: begin
        if (cmd == CMD_RELEASE) mode_next = M_ENTRY;
      end
      M_ENTRY, M_RETRY: begin
        if (cmd == CMD_TICK) begin
          if (matched) mode_next = M_CANCELED;
          else if (cd_zero) mode_next = M_ALERT;
          else if (full) mode_next = M_RETRY;
        end
      end
      M_CANCELED, M_ALERT: begin
        if (cmd == CMD_TICK && hold_zero) mode_next = M_IDLE;
      end
      default: mode_next = M_IDLE;
    endcase
  end

  // Entry, countdown and hold updates, and the result word
  always_comb begin
    state_next = state;
    vib        = VIB_NONE;
    alert      = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (entering) begin
          // advance the countdown, saturating at zero
          if (state.sub_ticks != '0) begin
            state_next.sub_ticks = state.sub_ticks - SUB_W'(1);
          end else if (state.secs != 8'd0) begin
            state_next.secs      = state.secs - 8'd1;
            state_next.sub_ticks = SUB_W'(TICKS_PER_SECOND - 1);
          end
          if (matched) begin
            state_next.hold_ticks = cfg.unlock_hold_ticks;
          end else if (full) begin
            state_next.entry_count  = '0;
            state_next.entry_digits = '0;
            vib                     = VIB_ERROR;
          end
          if (!matched && cd_zero) begin
            alert                 = 1'b1;
            vib                   = VIB_LONG;
            state_next.hold_ticks = cfg.alert_hold_ticks;
          end
        end else if (state.mode == M_CANCELED || state.mode == M_ALERT) begin
          if (state.hold_ticks != 8'd0) state_next.hold_ticks = state.hold_ticks - 8'd1;
          if (hold_zero) begin
            state_next.entry_count  = '0;
            state_next.entry_digits = '0;
          end
        end
      end
      CMD_PRESS: begin
        vib = VIB_SHORT;
      end
      CMD_RELEASE: begin
        vib = VIB_SHORT;
        if (state.mode == M_HELD) begin
          state_next.secs      = cfg.countdown_seconds;
          state_next.sub_ticks = '0;
        end
      end
      CMD_DIGIT: begin
        // store the digit in the next free slot; drop it when the entry is full
        if (entering && !full) begin
          for (int i = 0; i < CODE_LENGTH; i++) begin
            if (state.entry_count == CNT_W'(i)) state_next.entry_digits[i] = in_word.key_digit;
          end
          state_next.entry_count = state.entry_count + CNT_W'(1);
        end
      end
      default: ;
    endcase
    state_next.mode = mode_next;

    entering_next           = (mode_next == M_ENTRY) || (mode_next == M_RETRY);
    out_word.mode_now       = 3'(mode_next);
    out_word.digits_entered = 3'(state_next.entry_count);
    out_word.seconds_left   = entering_next ? (9'(state_next.secs) + 9'd1) : 9'd0;
    out_word.vibrate_code   = 2'(vib);
    out_word.send_alert     = alert;
    out_word.setup_warning  = !cfg.code_present;
  end

endmodule

@@ rtl/panic_alarm_passcode_fsm_core.sv @@
// Pipeline: a word accepted into the input register reaches out_word through the result
// register; the input register takes the next word while the last moves on, unless in_stall is high.
// Throughput: one word per cycle while not stalled; state steps through pap_step once per word.
// Reset (rst, synchronous): mode idle, entry and counters cleared, pipeline emptied,
// registers back to code 0, no passcode, 10 s countdown, holds of 20 and 100 ticks.
`include "panic_alarm_passcode_fsm_core_assert.svh"

module panic_alarm_passcode_fsm_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  pap_pkg::in_word_t            in_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output pap_pkg::out_word_t           out_word,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pap_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import pap_pkg::*;

  cfg_t      cfg;
  state_t    state;
  state_t    state_next;
  in_word_t  hold_word;
  logic      hold_valid;
  out_word_t result_next;
  logic      out_free;
  logic      advance;
  logic      cfg_write;
  logic [2:0] reg_index;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_digits       <= '0;
      cfg.code_present      <= 1'b0;
      cfg.countdown_seconds <= 8'd10;
      cfg.unlock_hold_ticks <= 8'd20;
      cfg.alert_hold_ticks  <= 8'd100;
    end else if (cfg_write) begin
      case (reg_index)
        REG_CODE_DIGITS:  cfg.code_digits       <= pwdata[CODE_BITS-1:0];
        REG_CODE_PRESENT: cfg.code_present      <= pwdata[0];
        REG_COUNTDOWN:    cfg.countdown_seconds <= pwdata[7:0];
        REG_UNLOCK_HOLD:  cfg.unlock_hold_ticks <= pwdata[7:0];
        REG_ALERT_HOLD:   cfg.alert_hold_ticks  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_CODE_DIGITS:  prdata = 32'(cfg.code_digits);
      REG_CODE_PRESENT: prdata = 32'(cfg.code_present);
      REG_COUNTDOWN:    prdata = 32'(cfg.countdown_seconds);
      REG_UNLOCK_HOLD:  prdata = 32'(cfg.unlock_hold_ticks);
      REG_ALERT_HOLD:   prdata = 32'(cfg.alert_hold_ticks);
      default:          prdata = 32'd0;
    endcase
  end

  // Flow control: the result register frees when empty or taken
  assign out_free = !out_valid || !out_stall;
  assign advance  = hold_valid && out_free;
  assign in_stall = hold_valid && !out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) hold_word <= in_word;
  end

  pap_step u_step (
    .state      (state),
    .cfg        (cfg),
    .in_word    (hold_word),
    .state_next (state_next),
    .out_word   (result_next)
  );

  // Controller state advances with each word moved to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode         <= M_IDLE;
      state.entry_count  <= '0;
      state.entry_digits <= '0;
      state.secs         <= '0;
      state.sub_ticks    <= '0;
      state.hold_ticks   <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_word <= result_next;
  end

  // Checks
  `PAP_ASSERT_NEXT(a_state_holds, clk, rst, !advance, $stable(state))
  `PAP_ASSERT_NEXT(a_word_delivered, clk, rst, advance, out_valid)
  `PAP_ASSERT_NOW(a_sub_in_range, clk, rst, 1'b1,
                  state.sub_ticks < SUB_W'(TICKS_PER_SECOND))
  `PAP_ASSERT_NOW(a_alert_long, clk, rst, out_valid && out_word.send_alert,
                  out_word.vibrate_code == 2'(VIB_LONG) && out_word.mode_now == 3'(M_ALERT))

endmodule
